>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define SCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/scd_pkg.sv
package scd_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // item actions
  localparam logic [1:0] ACT_SCAN = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // register indexes
  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_RATE  = 1'b1;

  localparam logic [15:0] REPEAT_DELAY_RST = 16'd50;
  localparam logic [15:0] REPEAT_RATE_RST  = 16'd3;

  localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
  localparam logic [6:0] SC_LSHIFT     = 7'h2A;
  localparam logic [6:0] SC_RSHIFT     = 7'h36;
  localparam logic [6:0] CH_PRINT_MIN  = 7'd32;
  localparam logic [6:0] NO_KEY        = 7'd0;

  typedef struct packed {
    logic [15:0] repeat_delay;
    logic [15:0] repeat_rate;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] ch;
  } push_t;

  function automatic logic [6:0] plain_map(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'd1:  ch = 7'h1B;
      7'd2:  ch = 7'h31;
      7'd3:  ch = 7'h32;
      7'd4:  ch = 7'h33;
      7'd5:  ch = 7'h34;
      7'd6:  ch = 7'h35;
      7'd7:  ch = 7'h36;
      7'd8:  ch = 7'h37;
      7'd9:  ch = 7'h38;
      7'd10: ch = 7'h39;
      7'd11: ch = 7'h30;
      7'd12: ch = 7'h2D;
      7'd13: ch = 7'h3D;
      7'd14: ch = 7'h08;
      7'd15: ch = 7'h09;
      7'd16: ch = 7'h71;
      7'd17: ch = 7'h77;
      7'd18: ch = 7'h65;
      7'd19: ch = 7'h72;
      7'd20: ch = 7'h74;
      7'd21: ch = 7'h79;
      7'd22: ch = 7'h75;
      7'd23: ch = 7'h69;
      7'd24: ch = 7'h6F;
      7'd25: ch = 7'h70;
      7'd26: ch = 7'h5B;
      7'd27: ch = 7'h5D;
      7'd28: ch = 7'h0A;
      7'd30: ch = 7'h61;
      7'd31: ch = 7'h73;
      7'd32: ch = 7'h64;
      7'd33: ch = 7'h66;
      7'd34: ch = 7'h67;
      7'd35: ch = 7'h68;
      7'd36: ch = 7'h6A;
      7'd37: ch = 7'h6B;
      7'd38: ch = 7'h6C;
      7'd39: ch = 7'h3B;
      7'd40: ch = 7'h27;
      7'd41: ch = 7'h60;
      7'd43: ch = 7'h5C;
      7'd44: ch = 7'h7A;
      7'd45: ch = 7'h78;
      7'd46: ch = 7'h63;
      7'd47: ch = 7'h76;
      7'd48: ch = 7'h62;
      7'd49: ch = 7'h6E;
      7'd50: ch = 7'h6D;
      7'd51: ch = 7'h2C;
      7'd52: ch = 7'h2E;
      7'd53: ch = 7'h2F;
      7'd55: ch = 7'h2A;
      7'd57: ch = 7'h20;
      7'd85: ch = 7'h2D;
      7'd87: ch = 7'h2B;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shift_map(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'd1:  ch = 7'h1B;
      7'd2:  ch = 7'h21;
      7'd3:  ch = 7'h40;
      7'd4:  ch = 7'h23;
      7'd5:  ch = 7'h24;
      7'd6:  ch = 7'h25;
      7'd7:  ch = 7'h5E;
      7'd8:  ch = 7'h26;
      7'd9:  ch = 7'h2A;
      7'd10: ch = 7'h28;
      7'd11: ch = 7'h29;
      7'd12: ch = 7'h5F;
      7'd13: ch = 7'h2B;
      7'd14: ch = 7'h08;
      7'd15: ch = 7'h09;
      7'd16: ch = 7'h51;
      7'd17: ch = 7'h57;
      7'd18: ch = 7'h45;
      7'd19: ch = 7'h52;
      7'd20: ch = 7'h54;
      7'd21: ch = 7'h59;
      7'd22: ch = 7'h55;
      7'd23: ch = 7'h49;
      7'd24: ch = 7'h4F;
      7'd25: ch = 7'h50;
      7'd26: ch = 7'h7B;
      7'd27: ch = 7'h7D;
      7'd28: ch = 7'h0A;
      7'd30: ch = 7'h41;
      7'd31: ch = 7'h53;
      7'd32: ch = 7'h44;
      7'd33: ch = 7'h46;
      7'd34: ch = 7'h47;
      7'd35: ch = 7'h48;
      7'd36: ch = 7'h4A;
      7'd37: ch = 7'h4B;
      7'd38: ch = 7'h4C;
      7'd39: ch = 7'h3A;
      7'd40: ch = 7'h22;
      7'd41: ch = 7'h7E;
      7'd43: ch = 7'h7C;
      7'd44: ch = 7'h5A;
      7'd45: ch = 7'h58;
      7'd46: ch = 7'h43;
      7'd47: ch = 7'h56;
      7'd48: ch = 7'h42;
      7'd49: ch = 7'h4E;
      7'd50: ch = 7'h4D;
      7'd51: ch = 7'h3C;
      7'd52: ch = 7'h3E;
      7'd53: ch = 7'h3F;
      7'd55: ch = 7'h2A;
      7'd57: ch = 7'h20;
      7'd85: ch = 7'h2D;
      7'd87: ch = 7'h2B;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/scd_regs.sv
module scd_regs
  import scd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [15:0] repeat_delay_r;
  logic [15:0] repeat_rate_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // low address bits are ignored, paddr[2] picks the register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_delay_r <= REPEAT_DELAY_RST;
      repeat_rate_r  <= REPEAT_RATE_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DELAY: repeat_delay_r <= pwdata[15:0];
        REG_RATE:  repeat_rate_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DELAY: prdata = {16'h0000, repeat_delay_r};
      REG_RATE:  prdata = {16'h0000, repeat_rate_r};
      default:   prdata = 32'h0;
    endcase
  end

  assign cfg.repeat_delay = repeat_delay_r;
  assign cfg.repeat_rate  = repeat_rate_r;

endmodule

>>> rtl/core/scd_keys.sv
module scd_keys
  import scd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [1:0] action,
  input  logic [7:0] scan_byte,
  input  cfg_t       cfg,
  output push_t      push
);

  logic        shift_r, shift_nxt;
  logic        ext_r, ext_nxt;
  logic [6:0]  key_r, key_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [6:0]  code;
  logic [6:0]  look_code;
  logic [6:0]  look_ch;

  assign code = scan_byte[6:0];

  // ticks look up the held key, bytes look up their own code
  assign look_code = (action == ACT_TICK) ? key_r : code;
  assign look_ch   = shift_r ? shift_map(look_code) : plain_map(look_code);

  always_comb begin
    shift_nxt  = shift_r;
    ext_nxt    = ext_r;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    push.valid = 1'b0;
    push.ch    = look_ch;
    if (en) begin
      case (action)
        ACT_SCAN: begin
          if (scan_byte == SC_EXT_PREFIX) begin
            ext_nxt = 1'b1;
          end else if (scan_byte[7]) begin
            if (code == SC_LSHIFT || code == SC_RSHIFT) shift_nxt = 1'b0;
            if (code == key_r) key_nxt = NO_KEY;
            ext_nxt = 1'b0;
          end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            shift_nxt = 1'b1;
            ext_nxt   = 1'b0;
          end else if (ext_r) begin
            ext_nxt = 1'b0;
          end else if (look_ch != 7'd0 && code != key_r) begin
            push.valid = 1'b1;
            if (look_ch >= CH_PRINT_MIN) begin
              key_nxt = code;
              cnt_nxt = cfg.repeat_delay;
            end else begin
              key_nxt = NO_KEY;
            end
          end
        end
        ACT_TICK: begin
          if (key_r != NO_KEY) begin
            if (cnt_r > 16'd1) begin
              cnt_nxt = cnt_r - 16'd1;
            end else begin
              push.valid = (look_ch >= CH_PRINT_MIN);
              cnt_nxt    = cfg.repeat_rate;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ext_r   <= 1'b0;
      key_r   <= NO_KEY;
      cnt_r   <= 16'd0;
    end else begin
      shift_r <= shift_nxt;
      ext_r   <= ext_nxt;
      key_r   <= key_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/scd_fifo.sv
module scd_fifo
  import scd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  logic       rd_en,
  output logic       rd_hit,
  output logic [6:0] rd_data_r
);

  localparam logic [FIFO_AW-1:0] PTR_LAST = FIFO_AW'(FIFO_DEPTH - 1);

  logic [6:0]         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r, head_nxt;
  logic [FIFO_AW-1:0] tail_r, tail_nxt;
  logic [FIFO_AW-1:0] head_inc;
  logic [FIFO_AW-1:0] tail_inc;
  logic               full;
  logic               wr_en;

  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
  // one slot stays empty so full and empty differ
  assign full     = (head_inc == tail_r);
  assign rd_hit   = (head_r != tail_r);
  assign wr_en    = push.valid & ~full;

  assign head_nxt = wr_en ? head_inc : head_r;
  assign tail_nxt = (rd_en && rd_hit) ? tail_inc : tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[head_r] <= push.ch;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[tail_r];
  end

endmodule

>>> rtl/core/scancode_set1_keyboard_decoder.sv
// Set-1 scancode decoder: one event per beat (scancode byte, timer tick or
// character read), accepted every cycle while the result path is not backed
// up. Shift and E0 prefix tracking, table lookup and auto-repeat counting
// settle in the accept cycle; characters land in a 256-entry ring buffer
// that keeps at most 255 and drops pushes when full. A read's beat passes
// through the buffer's registered read port, then the output register.
// Only reads produce output beats; an empty buffer returns char_valid 0
// with char_code 0. The buffer needs no clearing after reset. Write
// repeat_delay and repeat_rate only while no read is in flight.
module scancode_set1_keyboard_decoder
  import scd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_scan_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_char_valid,
  output logic [6:0]  out_char_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  push_t       push;
  logic        accept;
  logic        rd_en;
  logic        rd_hit;
  logic [6:0]  rd_data_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_hit_r;
  logic        s1_adv;
  logic        out_valid_r;
  logic        out_char_valid_r;
  logic [6:0]  out_char_code_r;

  assign s1_adv   = ~out_valid_r | out_ready;
  assign in_ready = ~s1_valid_r | s1_adv;
  assign accept   = in_valid & in_ready;
  assign rd_en    = accept & (in_action == ACT_READ);

  scd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scd_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (accept),
    .action    (in_action),
    .scan_byte (in_scan_byte),
    .cfg       (cfg),
    .push      (push)
  );

  scd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .rd_en     (rd_en),
    .rd_hit    (rd_hit),
    .rd_data_r (rd_data_r)
  );

  // read stage waits on the buffer's registered data
  assign s1_valid_nxt = rd_en | (s1_valid_r & ~s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) s1_hit_r <= rd_hit;
    if (s1_adv && s1_valid_r) begin
      out_char_valid_r <= s1_hit_r;
      out_char_code_r  <= s1_hit_r ? rd_data_r : 7'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = out_char_valid_r;
  assign out_char_code  = out_char_code_r;

endmodule

>>> rtl/core/scd_checker.sv
`include "assert_macros.svh"

module scd_checker
  import scd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic [7:0]  in_scan_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_char_valid,
  input logic [6:0]  out_char_code,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a new output beat only follows an accepted read, through the read stage
  `SCD_ASSERT(a_out_from_read, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready && in_action == ACT_READ, 2), "output beat without a read")

  // input stalls only when the output is backed up
  `SCD_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> (out_valid && !out_ready), "input stalled without output backpressure")

  // stalled output beat holds
  `SCD_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_char_valid) && $stable(out_char_code)), "output beat changed while stalled")

  // empty reads carry a zero code
  `SCD_ASSERT(a_empty_code, clk, rst_n, (out_valid && !out_char_valid) |-> (out_char_code == 7'd0), "empty read with nonzero code")

  `SCD_ASSERT_ALWAYS(a_pready, clk, pready, "config port not ready")

endmodule

bind scancode_set1_keyboard_decoder scd_checker u_scd_checker (.*);

>>> tb/keyboard_char_checker.sv
module keyboard_char_checker
  import scd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_scan_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_char_valid,
  input  logic [6:0]  out_char_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          reads_waiting,
  output int          beats_in,
  output int          chars_read,
  output int          empty_reads,
  output int          chars_dropped
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_CAPACITY = FIFO_DEPTH - 1;
  localparam int LAST_TBL_CODE = 57;

  // one byte per key code 0..57, code 0 in the top byte
  localparam bit [8*58-1:0] PLAIN_TBL = {
    64'h001B313233343536, 64'h373839302D3D0809, 64'h7177657274797569,
    64'h6F705B5D0A006173, 64'h646667686A6B6C3B, 64'h2760005C7A786376,
    64'h626E6D2C2E2F002A, 16'h0020};
  localparam bit [8*58-1:0] SHIFT_TBL = {
    64'h001B21402324255E, 64'h262A28295F2B0809, 64'h5157455254595549,
    64'h4F507B7D0A004153, 64'h444647484A4B4C3A, 64'h227E007C5A584356,
    64'h424E4D3C3E3F002A, 16'h0020};
  localparam logic [6:0] KP_MINUS_CODE = 7'd85;
  localparam logic [6:0] KP_PLUS_CODE  = 7'd87;

  typedef struct packed {
    logic       got;
    logic [6:0] code;
  } char_beat_t;

  logic [15:0] delay_reg;
  logic [15:0] rate_reg;
  logic        shift_on;
  logic        prefix_seen;
  logic [6:0]  held_key;
  logic [15:0] countdown;
  logic [6:0]  typed_chars[$];
  char_beat_t  reads_due[$];

  function automatic logic [6:0] key_char(input logic [6:0] code, input logic shifted);
    int   idx;
    logic [7:0] entry;
    entry = 8'h00;
    idx = LAST_TBL_CODE - int'(code);
    if (code <= LAST_TBL_CODE) begin
      entry = shifted ? SHIFT_TBL[idx*8 +: 8] : PLAIN_TBL[idx*8 +: 8];
    end else if (code == KP_MINUS_CODE) begin
      entry = 8'h2D;
    end else if (code == KP_PLUS_CODE) begin
      entry = 8'h2B;
    end
    return entry[6:0];
  endfunction

  function automatic void push_char(input logic [6:0] ch);
    if (typed_chars.size() >= BUF_CAPACITY) begin
      chars_dropped++;
    end else begin
      typed_chars.push_back(ch);
    end
  endfunction

  function automatic void decode_scan(input logic [7:0] sc);
    logic [6:0] ch;
    logic       is_shift;
    is_shift = (sc[6:0] == SC_LSHIFT) || (sc[6:0] == SC_RSHIFT);
    if (sc == SC_EXT_PREFIX) begin
      prefix_seen = 1'b1;
    end else if (sc[7]) begin
      if (is_shift) shift_on = 1'b0;
      if (sc[6:0] == held_key) held_key = NO_KEY;
      prefix_seen = 1'b0;
    end else if (is_shift) begin
      shift_on = 1'b1;
      prefix_seen = 1'b0;
    end else if (prefix_seen) begin
      prefix_seen = 1'b0;
    end else begin
      ch = key_char(sc[6:0], shift_on);
      if (ch != 7'd0 && sc[6:0] != held_key) begin
        push_char(ch);
        if (ch >= CH_PRINT_MIN) begin
          held_key = sc[6:0];
          countdown = delay_reg;
        end else begin
          held_key = NO_KEY;
        end
      end
    end
  endfunction

  function automatic void advance_repeat();
    logic [6:0] ch;
    if (held_key != NO_KEY) begin
      if (countdown > 16'd1) begin
        countdown--;
      end else begin
        ch = key_char(held_key, shift_on);
        if (ch >= CH_PRINT_MIN) push_char(ch);
        countdown = rate_reg;
      end
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  initial begin
    fail_count = 0;
    beats_in = 0;
    chars_read = 0;
    empty_reads = 0;
    chars_dropped = 0;
    reads_waiting = 0;
  end

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst_n) begin
      delay_reg = REPEAT_DELAY_RST;
      rate_reg = REPEAT_RATE_RST;
      shift_on = 1'b0;
      prefix_seen = 1'b0;
      held_key = NO_KEY;
      countdown = 16'd0;
      typed_chars.delete();
      reads_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_DELAY, 2'b00}) delay_reg = pwdata[15:0];
        else if (paddr == {REG_RATE, 2'b00}) rate_reg = pwdata[15:0];
      end

      if (out_valid && out_ready) begin
        if (reads_due.size() == 0) begin
          note_failure($sformatf("unexpected read beat: valid=%0b code=%h",
                                 out_char_valid, out_char_code));
        end else begin
          want = reads_due.pop_front();
          if (want.got !== out_char_valid || want.code !== out_char_code)
            note_failure($sformatf("read beat mismatch: expected valid=%0b code=%h, got valid=%0b code=%h",
                                   want.got, want.code, out_char_valid, out_char_code));
        end
      end

      if (in_valid && in_ready) begin
        beats_in++;
        case (in_action)
          ACT_SCAN: decode_scan(in_scan_byte);
          ACT_TICK: advance_repeat();
          ACT_READ: begin
            if (typed_chars.size() == 0) begin
              reads_due.push_back('{got: 1'b0, code: 7'd0});
              empty_reads++;
            end else begin
              reads_due.push_back('{got: 1'b1, code: typed_chars.pop_front()});
              chars_read++;
            end
          end
          default: ;
        endcase
      end
    end
    reads_waiting <= reads_due.size();
  end

endmodule

>>> tb/scancode_set1_keyboard_decoder_tb.sv
module scancode_set1_keyboard_decoder_tb;
  import scd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [7:0] RELEASE_BIT = 8'h80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_SCAN;
  logic [7:0]  in_scan_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_char_valid;
  logic [6:0]  out_char_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, reads_waiting, beats_in, chars_read, empty_reads, chars_dropped;

  int snd_idle = 0;
  int rcv_stall = 0;
  int read_pct = 20;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  logic [6:0] last_key = 7'h1E;

  scancode_set1_keyboard_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_scan_byte  (in_scan_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_valid(out_char_valid),
    .out_char_code (out_char_code),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  keyboard_char_checker u_char_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_scan_byte  (in_scan_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_valid(out_char_valid),
    .out_char_code (out_char_code),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .reads_waiting (reads_waiting),
    .beats_in      (beats_in),
    .chars_read    (chars_read),
    .empty_reads   (empty_reads),
    .chars_dropped (chars_dropped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("scancode_set1_keyboard_decoder_tb: done, errors");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [7:0] sc);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_scan_byte <= sc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_scan(input logic [7:0] sc);
    send_item(ACT_SCAN, sc);
  endtask

  // wait out every read in flight before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (reads_waiting != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    snd_idle = snd;
    rcv_stall <= rcv;
  endtask

  function automatic logic [6:0] pick_key();
    int r;
    r = $urandom_range(0, 59);
    if (r == 58) return 7'd85;
    if (r == 59) return 7'd87;
    return 7'(r);
  endfunction

  // mostly typing: presses, releases, shift, prefixes, ticks and reads
  task automatic typing_burst(input int n);
    int done;
    int r;
    int s;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (r < 30) begin
        send_item(ACT_TICK, 8'($urandom()));
      end else if (r < 30 + read_pct) begin
        send_item(ACT_READ, 8'($urandom()));
      end else if (s < 45) begin
        last_key = pick_key();
        send_scan({1'b0, last_key});
      end else if (s < 65) begin
        send_scan(RELEASE_BIT | last_key);
      end else if (s < 73) begin
        send_scan($urandom_range(0, 1) ? {1'b0, SC_LSHIFT} : {1'b0, SC_RSHIFT});
      end else if (s < 80) begin
        send_scan(RELEASE_BIT | ($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT));
      end else if (s < 87) begin
        send_scan(SC_EXT_PREFIX);
      end else if (s < 95) begin
        send_scan(8'($urandom()));
      end else begin
        send_item(ACT_UNUSED, 8'($urandom()));
        done--;
      end
      done++;
    end
  endtask

  initial begin
    int i;
    logic [6:0] flood_key;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: short delay, zero rate repeats on every tick
    write_reg(REG_DELAY, 16'd2);
    write_reg(REG_RATE, 16'd0);
    send_item(ACT_READ, 8'h00);
    send_scan(8'h1E);
    send_scan(8'h1E);
    repeat (3) send_item(ACT_TICK, 8'hFF);
    send_scan(8'h9E);
    send_item(ACT_TICK, 8'h00);
    send_scan({1'b0, SC_LSHIFT});
    send_scan(8'h10);
    send_scan(RELEASE_BIT | SC_LSHIFT);
    send_scan(8'h39);
    send_scan(8'h0E);
    send_scan(SC_EXT_PREFIX);
    send_scan(8'h1C);
    send_scan(SC_EXT_PREFIX);
    send_scan({1'b0, SC_RSHIFT});
    send_scan(8'h02);
    send_scan(RELEASE_BIT | SC_RSHIFT);
    send_scan(8'h3B);
    send_scan(8'h57);
    send_scan(8'h00);
    send_scan(8'hFF);
    send_item(ACT_UNUSED, 8'hA5);
    for (i = 0; i < 10; i++) send_item(ACT_READ, 8'h00);
    drain();

    write_reg(REG_DELAY, 16'hFFFF);
    write_reg(REG_RATE, 16'hFFFF);
    set_idling(0, 0);
    typing_burst(40);
    drain();

    write_reg(REG_DELAY, 16'd0);
    write_reg(REG_RATE, 16'd1);
    set_idling(73, 0);
    typing_burst(40);
    drain();

    write_reg(REG_DELAY, 16'd3);
    write_reg(REG_RATE, 16'd2);
    set_idling(0, 73);
    typing_burst(40);
    drain();

    // read-heavy while the receiver holds off: output path backs up
    write_reg(REG_DELAY, 16'($urandom_range(0, 6)));
    write_reg(REG_RATE, 16'($urandom_range(1, 3)));
    set_idling(32, 32);
    read_pct = 45;
    hold_go <= ~hold_go;
    typing_burst(40);
    read_pct = 20;
    drain();

    // fill the character buffer past capacity with one held key
    write_reg(REG_DELAY, 16'd1);
    write_reg(REG_RATE, 16'd1);
    set_idling(0, 0);
    flood_key = 7'($urandom_range(16, 25));
    send_scan(RELEASE_BIT | flood_key);
    send_scan({1'b0, flood_key});
    for (i = 0; i < 262; i++) send_item(ACT_TICK, 8'($urandom()));
    send_scan(RELEASE_BIT | flood_key);
    for (i = 0; i < 40; i++) send_item(ACT_READ, 8'($urandom()));
    drain();

    write_reg(REG_DELAY, 16'd0);
    write_reg(REG_RATE, 16'hFFFF);
    set_idling(32, 32);
    typing_burst(40);

    in_valid <= 1'b0;
    do @(posedge clk); while (reads_waiting != 0);
    repeat (8) @(posedge clk);

    $display("%0d beats in; %0d reads checked (%0d with a char, %0d empty)",
             beats_in, chars_read + empty_reads, chars_read, empty_reads);
    $display("%0d chars dropped on a full buffer; repeat delay/rate swept 0..65535",
             chars_dropped);
    if (fail_count == 0) begin
      $display("scancode_set1_keyboard_decoder_tb: done, clean");
    end else begin
      $display("scancode_set1_keyboard_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/scd_pkg.sv
rtl/core/scd_regs.sv
rtl/core/scd_keys.sv
rtl/core/scd_fifo.sv
rtl/core/scancode_set1_keyboard_decoder.sv
rtl/core/scd_checker.sv
tb/keyboard_char_checker.sv
tb/scancode_set1_keyboard_decoder_tb.sv
